>>> hdl/arrt_pkg.sv
`default_nettype none
package arrt_pkg;

    localparam int ADDR_W  = 64;
    localparam int OWNER_W = 32;
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 2;

    typedef enum logic [1:0] {
        MODE_RESERVE  = 2'd0,
        MODE_CLAIM    = 2'd1,
        MODE_RELEASE  = 2'd2,
        MODE_CONTAINS = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Control states of the top level.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    // Request broadcast to all cells while a scan runs.
    typedef struct packed {
        t_mode               mode;
        logic [ADDR_W-1:0]   base;
        logic [ADDR_W-1:0]   len;
        logic [ADDR_W-1:0]   last;
        logic [KIND_W-1:0]   kind;
        logic [OWNER_W-1:0]  owner;
    } t_req;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic vld;
        logic hit;
        logic free;
    } t_tok;

    // End-of-scan command to all cells.
    typedef struct packed {
        logic go;
        logic commit;
    } t_cmd;

endpackage
`default_nettype wire

>>> hdl/address_range_reservation_table_core.sv
`default_nettype none
// Address range reservation table.
// Requests arrive on the s_axis channel, one transfer per request; tdata holds
// mode, range base, range length, range kind and owner id. Each request gives
// exactly one result transfer on m_axis carrying status, covered flag and the
// number of active entries after the request.
// The table is a chain of TABLE_SLOTS cells, one slot per cell. A scan token
// walks the chain one cell per cycle, collecting overlap, match and free-slot
// flags; a release frees its slot as the token passes. At the end of the chain
// an insert is committed into the lowest free cell, which marked itself during
// the scan.
// A request that reaches the chain passes every cell's token register, has its
// status registered at the end of the chain and then enters the output
// register; one rejected by the input checks skips the chain. One request is in
// flight at a time; the next is taken once the previous result is registered.
// The next request is taken while a result still waits in the output register.
// Reset clears all valid bits and the entry count at once; slot contents are
// left as they are. If the receiver stalls, a finished result waits, and the
// block stops accepting requests once a second result is ready.
module address_range_reservation_table_core #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [1:0] mode, [65:2] range_base, [129:66] range_length,
    // [131:130] range_kind, [163:132] owner_id, [167:164] zero
    input  wire logic [167:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [1:0] status, [2] covered, [7:3] entry_count
    output logic [7:0]        m_axis_tdata
);
    import arrt_pkg::*;

    localparam int CW = $clog2(TABLE_SLOTS + 1);

    t_state            r_state, n_state;
    t_req              r_req;
    logic              r_launch;
    logic [CW-1:0]     r_cnt;
    t_status           r_status;
    logic              r_cov;
    logic              r_out_vld;
    logic [7:0]        r_out;

    t_tok              tok [0:TABLE_SLOTS];
    t_cmd              cmd;

    logic              accept;
    logic [ADDR_W:0]   sum;
    logic              span_bad;
    logic              ins_bad;
    logic              in_ins;
    t_mode             in_mode;
    logic              out_free;
    logic [CW+4:0]     cnt_ext;

    assign in_mode  = t_mode'(s_axis_tdata[1:0]);
    assign sum      = {1'b0, s_axis_tdata[65:2]} + {1'b0, s_axis_tdata[129:66]}
                      - {{ADDR_W{1'b0}}, 1'b1};
    assign span_bad = (s_axis_tdata[129:66] == '0) || sum[ADDR_W];
    assign in_ins   = (in_mode == MODE_RESERVE) || (in_mode == MODE_CLAIM);
    assign ins_bad  = span_bad || (s_axis_tdata[163:132] == '0) || s_axis_tdata[131];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    // The token enters the first cell the cycle after the request is latched.
    assign tok[0] = '{vld: r_launch, hit: 1'b0, free: 1'b0};

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        arrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_req  (r_req),
            .i_tok  (tok[g]),
            .i_cmd  (cmd),
            .o_tok  (tok[g+1])
        );
    end

    logic req_ins;
    assign req_ins = (r_req.mode == MODE_RESERVE) || (r_req.mode == MODE_CLAIM);

    always_comb begin
        cmd.go     = tok[TABLE_SLOTS].vld;
        cmd.commit = req_ins && !tok[TABLE_SLOTS].hit && tok[TABLE_SLOTS].free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = (span_bad || (in_ins && ins_bad)) ? S_FIN : S_RUN;
            end
            S_RUN: begin
                if (tok[TABLE_SLOTS].vld) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept && !(span_bad || (in_ins && ins_bad));
            if (cmd.go) begin
                if (cmd.commit) r_cnt <= r_cnt + CW'(1);
                else if (r_req.mode == MODE_RELEASE && tok[TABLE_SLOTS].hit)
                    r_cnt <= r_cnt - CW'(1);
            end
            if (r_state == S_FIN && out_free) r_out_vld <= 1'b1;
            else if (m_axis_tready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.mode  <= in_mode;
            r_req.base  <= s_axis_tdata[65:2];
            r_req.len   <= s_axis_tdata[129:66];
            r_req.last  <= sum[ADDR_W-1:0];
            r_req.kind  <= s_axis_tdata[131:130];
            r_req.owner <= s_axis_tdata[163:132];
            r_status    <= ST_INVALID;
            r_cov       <= 1'b0;
        end
        if (cmd.go) begin
            if (req_ins) begin
                if (tok[TABLE_SLOTS].hit)       r_status <= ST_OVERLAP;
                else if (!tok[TABLE_SLOTS].free) r_status <= ST_FULL;
                else                            r_status <= ST_OK;
            end else if (r_req.mode == MODE_RELEASE) begin
                r_status <= tok[TABLE_SLOTS].hit ? ST_OK : ST_INVALID;
            end else begin
                r_status <= ST_OK;
                r_cov    <= tok[TABLE_SLOTS].hit;
            end
        end
        if (r_state == S_FIN && out_free) r_out <= {cnt_ext[4:0], r_cov, r_status};
    end

    assign cnt_ext       = {5'd0, r_cnt};
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule
`default_nettype wire

>>> hdl/arrt_cell.sv
`default_nettype none
module arrt_cell (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire arrt_pkg::t_req i_req,
    input  wire arrt_pkg::t_tok i_tok,
    input  wire arrt_pkg::t_cmd i_cmd,
    output arrt_pkg::t_tok    o_tok
);
    import arrt_pkg::*;

    logic               r_valid;
    logic               r_pend;
    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W-1:0]  r_len;
    logic [ADDR_W-1:0]  r_last;
    logic               r_kind;
    logic [OWNER_W-1:0] r_owner;
    logic               r_locked;
    t_tok               r_tok;
    t_tok               n_tok;
    logic               n_pend;
    logic               n_free_slot;

    logic               kind_eq;
    logic               meet;
    logic               exact;
    logic [ADDR_W-1:0]  off;
    logic               covers;
    logic               is_ins;

    always_comb begin
        kind_eq = (i_req.kind[1] == 1'b0) && (i_req.kind[0] == r_kind);
        meet    = (i_req.base <= r_last) && (r_base <= i_req.last);
        exact   = (r_base == i_req.base) && (r_len == i_req.len) &&
                  (r_owner == i_req.owner) && !r_locked;
        off     = i_req.base - r_base;
        covers  = (i_req.base >= r_base) && (off <= r_len) && (i_req.len <= r_len - off);
        is_ins  = (i_req.mode == MODE_RESERVE) || (i_req.mode == MODE_CLAIM);

        n_tok       = i_tok;
        n_pend      = 1'b0;
        n_free_slot = 1'b0;
        if (i_tok.vld) begin
            if (is_ins) begin
                if (r_valid) begin
                    if (kind_eq && meet) n_tok.hit = 1'b1;
                end else if (!i_tok.free) begin
                    n_tok.free = 1'b1;
                    n_pend     = 1'b1;
                end
            end else if (i_req.mode == MODE_RELEASE) begin
                if (!i_tok.hit && r_valid && kind_eq && exact) begin
                    n_tok.hit   = 1'b1;
                    n_free_slot = 1'b1;
                end
            end else begin
                if (r_valid && kind_eq && covers) n_tok.hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (n_pend) r_pend <= 1'b1;
            if (n_free_slot) r_valid <= 1'b0;
            if (i_cmd.go) begin
                r_pend <= 1'b0;
                if (i_cmd.commit && r_pend) r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.go && i_cmd.commit && r_pend) begin
            r_base   <= i_req.base;
            r_len    <= i_req.len;
            r_last   <= i_req.last;
            r_kind   <= i_req.kind[0];
            r_owner  <= i_req.owner;
            r_locked <= (i_req.mode == MODE_RESERVE);
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire
